FILE: design/idq_pkg.sv
package idq_pkg;

  // ring size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 4) ? CNT_W : 4;
  localparam int SUM_W    = CNT_W + 1;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int ECNT_W   = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_AT    = 3'd4,
    CMD_WRITE_AT   = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [ECNT_W-1:0]         element_count;
    logic [STATUS_W-1:0]       status;
  } rsp_t;

  // (base + offset) mod CAPACITY, offset known to be at most CAPACITY
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: design/integer_deque_core.sv
// bounded double-ended queue of signed 32-bit integers held in a ring buffer
//
// request channel (req_valid / req_ready / req): one command per request,
// push front or back, pop front or back, read or overwrite at a position
// counted from the front, or clear. command seven is ignored.
// response channel (rsp_valid / rsp_ready / rsp): exactly one response per
// request, in order: popped or read value (zero otherwise), element count
// after the command, and a status of ok, full, empty or out of range.
//
// latency: the response is valid the cycle after the request is taken.
// throughput: one request per cycle; the single-port element memory is
// read or written once per request and the pointers update at acceptance.
// a stalled response holds in the output register and req_ready drops
// until the response is taken (or is taken in the same cycle).
// reset: front pointer and count clear, no response pending; the element
// memory is not cleared and only written entries are ever read.
module integer_deque_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  idq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output idq_pkg::rsp_t  rsp
);

  localparam int IDX_W = idq_pkg::IDX_W;
  localparam int CNT_W = idq_pkg::CNT_W;
  localparam int CMP_W = idq_pkg::CMP_W;
  localparam int WIDE_W = CNT_W + idq_pkg::ECNT_W;

  // element memory, one access per request, registered read data
  logic [idq_pkg::VALUE_W-1:0] mem [idq_pkg::CAPACITY];
  logic [idq_pkg::VALUE_W-1:0] rd_data;

  // queue pointers
  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // output register
  logic                         rsp_read;
  logic [idq_pkg::ECNT_W-1:0]   rsp_count;
  idq_pkg::status_e_t           rsp_status;

  // per-request decode
  logic                take;
  logic                mem_wr;
  logic                mem_rd;
  logic [IDX_W-1:0]    mem_idx;
  logic                is_full;
  logic                is_empty;
  logic                pos_bad;
  idq_pkg::status_e_t  status_next;
  logic [WIDE_W-1:0]   cnt_wide;

  // output register frees as it is taken
  assign req_ready = !rsp_valid || rsp_ready;
  assign take      = req_valid && req_ready;

  assign is_full  = (cnt == CNT_W'(idq_pkg::CAPACITY));
  assign is_empty = (cnt == '0);
  assign pos_bad  = (CMP_W'(req.position) >= CMP_W'(cnt));

  always_comb begin
    front_next  = front;
    cnt_next    = cnt;
    mem_wr      = 1'b0;
    mem_rd      = 1'b0;
    mem_idx     = front;
    status_next = idq_pkg::ST_OK;
    case (idq_pkg::cmd_e_t'(req.command))
      idq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_next = idq_pkg::ST_FULL;
        end else begin
          front_next = (front == '0) ? IDX_W'(idq_pkg::CAPACITY - 1) : front - 1'b1;
          mem_idx    = front_next;
          mem_wr     = 1'b1;
          cnt_next   = cnt + 1'b1;
        end
      end
      idq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_next = idq_pkg::ST_FULL;
        end else begin
          mem_idx  = idq_pkg::ring_add(front, cnt);
          mem_wr   = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      idq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          status_next = idq_pkg::ST_EMPTY;
        end else begin
          mem_idx    = front;
          mem_rd     = 1'b1;
          front_next = idq_pkg::ring_add(front, CNT_W'(1));
          cnt_next   = cnt - 1'b1;
        end
      end
      idq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          status_next = idq_pkg::ST_EMPTY;
        end else begin
          mem_idx  = idq_pkg::ring_add(front, cnt - 1'b1);
          mem_rd   = 1'b1;
          cnt_next = cnt - 1'b1;
        end
      end
      idq_pkg::CMD_READ_AT: begin
        if (pos_bad) begin
          status_next = idq_pkg::ST_RANGE;
        end else begin
          mem_idx = idq_pkg::ring_add(front, CNT_W'(req.position));
          mem_rd  = 1'b1;
        end
      end
      idq_pkg::CMD_WRITE_AT: begin
        if (pos_bad) begin
          status_next = idq_pkg::ST_RANGE;
        end else begin
          mem_idx = idq_pkg::ring_add(front, CNT_W'(req.position));
          mem_wr  = 1'b1;
        end
      end
      idq_pkg::CMD_CLEAR: begin
        front_next = '0;
        cnt_next   = '0;
      end
      default: begin
        // unused command code: no change, status ok
      end
    endcase
  end

  // element count reported masked to the field width
  assign cnt_wide = WIDE_W'(cnt_next);

  // element memory: pointers move at acceptance, so a later read of an
  // entry always sees an earlier write without forwarding
  always_ff @(posedge clk) begin
    if (take && mem_wr) begin
      mem[mem_idx] <= req.value;
    end
    if (take && mem_rd) begin
      rd_data <= mem[mem_idx];
    end
  end

  // pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        front     <= front_next;
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      rsp_read   <= mem_rd;
      rsp_count  <= cnt_wide[idq_pkg::ECNT_W-1:0];
      rsp_status <= status_next;
    end
  end

  assign rsp.result_value  = rsp_read ? rd_data : '0;
  assign rsp.element_count = rsp_count;
  assign rsp.status        = rsp_status;

endmodule

FILE: design/idq_checker.sv
module idq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input idq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input idq_pkg::rsp_t rsp
);

  // a full queue reports capacity as its count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == idq_pkg::ST_FULL) |->
      (rsp.element_count == idq_pkg::ECNT_W'(idq_pkg::CAPACITY)))
    else $error("full status with count other than capacity");

  // empty pop leaves nothing and returns zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == idq_pkg::ST_EMPTY) |->
      (rsp.element_count == '0 && rsp.result_value == '0))
    else $error("empty status with nonzero count or value");

  // failed push or bad position returns zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == idq_pkg::ST_FULL || rsp.status == idq_pkg::ST_RANGE)) |->
      (rsp.result_value == '0))
    else $error("nonzero value on full or range status");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("response changed while stalled");

endmodule

bind integer_deque_core idq_checker u_idq_checker (.*);

FILE: bench/integer_deque_core_tb.sv
module integer_deque_core_tb;
  import idq_pkg::*;

  // the one command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_IGNORED = 3'd7;

  // random request counts per idling phase
  localparam int unsigned PHASE_ITEMS = 584;

  // scoreboard: mirrors the ring buffer and holds the responses still owed
  class deque_scoreboard;
    logic signed [VALUE_W-1:0] ring [CAPACITY];
    int unsigned head;
    int unsigned held;
    rsp_t owed_rsps[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned peak;
    int unsigned status_hits [4];
    int unsigned cmd_hits [8];

    function new();
      head = 0;
      held = 0;
      errors = 0;
      checked = 0;
      peak = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      foreach (cmd_hits[i]) cmd_hits[i] = 0;
    endfunction

    function int unsigned outstanding();
      return owed_rsps.size();
    endfunction

    function int unsigned depth();
      return held;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // work out the response an accepted request must produce
    function void note_command(req_t r);
      rsp_t e;
      e = '0;
      e.status = ST_OK;
      case (r.command)
        CMD_PUSH_FRONT: begin
          if (held >= CAPACITY) begin
            e.status = ST_FULL;
          end else begin
            head = (head + CAPACITY - 1) % CAPACITY;
            ring[head] = r.value;
            held++;
          end
        end
        CMD_PUSH_BACK: begin
          if (held >= CAPACITY) begin
            e.status = ST_FULL;
          end else begin
            ring[(head + held) % CAPACITY] = r.value;
            held++;
          end
        end
        CMD_POP_FRONT: begin
          if (held == 0) begin
            e.status = ST_EMPTY;
          end else begin
            e.result_value = ring[head];
            head = (head + 1) % CAPACITY;
            held--;
          end
        end
        CMD_POP_BACK: begin
          if (held == 0) begin
            e.status = ST_EMPTY;
          end else begin
            e.result_value = ring[(head + held - 1) % CAPACITY];
            held--;
          end
        end
        CMD_READ_AT: begin
          if (r.position >= held) begin
            e.status = ST_RANGE;
          end else begin
            e.result_value = ring[(head + r.position) % CAPACITY];
          end
        end
        CMD_WRITE_AT: begin
          if (r.position >= held) begin
            e.status = ST_RANGE;
          end else begin
            ring[(head + r.position) % CAPACITY] = r.value;
          end
        end
        CMD_CLEAR: begin
          head = 0;
          held = 0;
        end
        default: ;
      endcase
      e.element_count = ECNT_W'(held);
      if (held > peak) peak = held;
      cmd_hits[r.command]++;
      status_hits[e.status]++;
      owed_rsps.insert(owed_rsps.size(), e);
    endfunction

    // compare one accepted response with the oldest one owed
    task check_result(rsp_t got);
      rsp_t want;
      if (owed_rsps.size() == 0) begin
        report($sformatf("response with nothing owed: value %h count %0d status %0d",
                         got.result_value, got.element_count, got.status));
        return;
      end
      want = owed_rsps.pop_front();
      checked++;
      if (got.result_value !== want.result_value)
        report($sformatf("response %0d result_value %h, wanted %h",
                         checked, got.result_value, want.result_value));
      if (got.element_count !== want.element_count)
        report($sformatf("response %0d element_count %0d, wanted %0d",
                         checked, got.element_count, want.element_count));
      if (got.status !== want.status)
        report($sformatf("response %0d status %0d, wanted %0d",
                         checked, got.status, want.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // idling odds in percent, changed between phases
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  deque_scoreboard sb = new();

  integer_deque_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // response monitor, sampled on the rising edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check_result(rsp);
    end
  end

  function automatic req_t make_req(input logic [CMD_W-1:0] cmd,
                                    input logic signed [VALUE_W-1:0] val,
                                    input logic [POS_W-1:0] pos);
    req_t r;
    r.command  = cmd;
    r.value    = val;
    r.position = pos;
    return r;
  endfunction

  // drive one request from a falling edge until the block takes it;
  // valid only drops when the sender decides to idle before the next one
  task automatic send_command(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_command(r);
    @(negedge clk);
  endtask

  // hold the sender back until every owed response has come
  task automatic drain_responses();
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // random traffic; the mix drifts between filling, draining and balanced
  // so that both the full and the empty corners are visited often
  task automatic run_random(input int unsigned n_items);
    req_t r;
    int unsigned pick;
    int unsigned trend;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned level;
    trend = 1;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 48 == 0) trend = $urandom_range(2);
      push_pct = (trend == 2) ? 60 : (trend == 1) ? 30 : 12;
      pop_pct  = (trend == 0) ? 60 : (trend == 1) ? 30 : 12;
      level = sb.depth();
      pick  = $urandom_range(99);
      if (pick < push_pct) begin
        r.command = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else if (pick < push_pct + pop_pct) begin
        r.command = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end else if (pick < 98) begin
        r.command = $urandom_range(1) ? CMD_WRITE_AT : CMD_READ_AT;
      end else if (pick == 98) begin
        r.command = CMD_CLEAR;
      end else begin
        r.command = CMD_IGNORED;
      end
      // mostly a held position, sometimes anything the field allows
      if (level > 0 && $urandom_range(3) != 0) begin
        r.position = POS_W'($urandom_range(level - 1));
      end else begin
        r.position = POS_W'($urandom_range(15));
      end
      case ($urandom_range(7))
        0:       r.value = 32'sh8000_0000;
        1:       r.value = 32'sh7fff_ffff;
        2:       r.value = '0;
        3:       r.value = -32'sd1;
        default: r.value = $urandom;
      endcase
      send_command(r);
    end
  endtask

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("** integer_deque_core: FAILED **");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    rsp_ready      = 1'b0;
    send_idle_pct  = 19;
    recv_stall_pct = 68;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queue corners and the ignored command
    send_command(make_req(CMD_POP_FRONT, 32'sd5, 4'd0));
    send_command(make_req(CMD_POP_BACK, 32'sd5, 4'd0));
    send_command(make_req(CMD_READ_AT, 32'sd0, 4'd0));
    send_command(make_req(CMD_IGNORED, 32'sh1234_5678, 4'd3));
    // extremes of the value field, pointer wrap on push front
    send_command(make_req(CMD_PUSH_FRONT, 32'sh8000_0000, 4'd0));
    send_command(make_req(CMD_PUSH_BACK, 32'sh7fff_ffff, 4'd0));
    send_command(make_req(CMD_READ_AT, 32'sd0, 4'd1));
    send_command(make_req(CMD_WRITE_AT, -32'sd1, 4'd0));
    send_command(make_req(CMD_POP_BACK, 32'sd0, 4'd0));
    // fill to capacity from both ends
    for (int unsigned k = 0; k < CAPACITY - 1; k++) begin
      send_command(make_req(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                            $signed(32'(k) * 32'h1111_1111), 4'd0));
    end
    // push when full, the last position, then empty it all
    send_command(make_req(CMD_PUSH_FRONT, 32'sd99, 4'd0));
    send_command(make_req(CMD_READ_AT, 32'sd0, 4'd15));
    send_command(make_req(CMD_WRITE_AT, 32'sh5a5a_a5a5, 4'd15));
    send_command(make_req(CMD_POP_FRONT, 32'sd0, 4'd0));
    send_command(make_req(CMD_CLEAR, 32'sd0, 4'd0));
    req_valid <= 1'b0;
    drain_responses();

    // sender mostly busy, receiver mostly stalled
    run_random(PHASE_ITEMS);
    req_valid <= 1'b0;
    drain_responses();

    // the other way round
    send_idle_pct  = 68;
    recv_stall_pct = 19;
    run_random(PHASE_ITEMS);
    req_valid <= 1'b0;
    drain_responses();

    // back to back at full rate
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);
    req_valid <= 1'b0;
    drain_responses();
    repeat (4) @(negedge clk);

    if (sb.outstanding() != 0) sb.report("responses still owed at the end");
    $display("covered %0d requests: %0d push on full, %0d pop on empty, %0d bad position,",
             sb.checked, sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_RANGE]);
    $display("  %0d clears, %0d ignored commands, peak fill %0d of %0d",
             sb.cmd_hits[CMD_CLEAR], sb.cmd_hits[CMD_IGNORED], sb.peak, CAPACITY);
    if (sb.errors == 0) begin
      $display("** integer_deque_core: PASSED **");
    end else begin
      $display("** integer_deque_core: FAILED **");
    end
    $finish;
  end

endmodule
